FILE: src/mme_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Shared opcodes, register codes, widths and control structs.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int MAX_DIM_DEF    = 8;
	localparam int ELEM_WIDTH_DEF = 16;

	localparam int OPC_W   = 2;
	localparam int IDX_W   = 3;
	localparam int VALUE_W = 16;
	localparam int CFG_W   = 4;
	localparam int ACC_W   = 36;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [OPC_W-1:0] OP_LOAD_A  = 2'd0;
	localparam logic [OPC_W-1:0] OP_LOAD_B  = 2'd1;
	localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd2;

	localparam logic [1:0] REG_ROWS_A     = 2'd0;
	localparam logic [1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [1:0] REG_COLS_B     = 2'd2;

	// Command from the sequencer to the datapath for one cycle.
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             rd;
		logic             first;
		logic             last_elem;
		logic             last_all;
		logic [IDX_W-1:0] out_row;
		logic [IDX_W-1:0] out_col;
	} cmd_t;

	// Tag that travels alongside a product through the datapath.
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last_elem;
		logic             last_all;
		logic [IDX_W-1:0] out_row;
		logic [IDX_W-1:0] out_col;
	} tag_t;

endpackage

FILE: src/mme_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/mme_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix multiply sequencer
// Decodes requests and walks (i, j, k) issuing one read pair per cycle.
// ----------------------------------------------------------------------------
module mme_ctrl #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF,
	localparam int CW = $clog2(MAX_DIM),
	localparam int SW = $clog2(MAX_DIM + 1),
	localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mme_pkg::OPC_W-1:0] opcode,
	input  logic [mme_pkg::IDX_W-1:0] row_index,
	input  logic [mme_pkg::IDX_W-1:0] col_index,
	input  logic [SW-1:0]             nr,
	input  logic [SW-1:0]             nk,
	input  logic [SW-1:0]             nc,
	output logic                      busy,
	output mme_pkg::cmd_t             cmd,
	output logic [AW-1:0]             rd_addr_a,
	output logic [AW-1:0]             rd_addr_b
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic          state_q;
	logic [CW-1:0] i_q, j_q, k_q;
	logic          accept;
	logic          i_last, j_last, k_last;
	logic          row_ok_a, col_ok_a, row_ok_b, col_ok_b;

	assign busy   = (state_q == ST_RUN);
	assign accept = start && !busy;

	assign i_last = (SW'(i_q) + SW'(1)) == nr;
	assign j_last = (SW'(j_q) + SW'(1)) == nc;
	assign k_last = (SW'(k_q) + SW'(1)) == nk;

	assign row_ok_a = 32'(row_index) < 32'(nr);
	assign col_ok_a = 32'(col_index) < 32'(nk);
	assign row_ok_b = 32'(row_index) < 32'(nk);
	assign col_ok_b = 32'(col_index) < 32'(nc);

	assign rd_addr_a = AW'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign rd_addr_b = AW'(32'(k_q) * MAX_DIM + 32'(j_q));

	always_comb begin
		cmd           = '0;
		cmd.wr_a      = accept && (opcode == mme_pkg::OP_LOAD_A) && row_ok_a && col_ok_a;
		cmd.wr_b      = accept && (opcode == mme_pkg::OP_LOAD_B) && row_ok_b && col_ok_b;
		cmd.rd        = busy;
		cmd.first     = (k_q == '0);
		cmd.last_elem = k_last;
		cmd.last_all  = k_last && j_last && i_last;
		cmd.out_row   = mme_pkg::IDX_W'(i_q);
		cmd.out_col   = mme_pkg::IDX_W'(j_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == mme_pkg::OP_COMPUTE)) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (!k_last) begin
						k_q <= k_q + CW'(1);
					end else begin
						k_q <= '0;
						if (!j_last) begin
							j_q <= j_q + CW'(1);
						end else begin
							j_q <= '0;
							if (!i_last) begin
								i_q <= i_q + CW'(1);
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/mme_dp.sv
// ----------------------------------------------------------------------------
// Matrix multiply datapath
// Element stores, one multiplier and one accumulator with result register.
// ----------------------------------------------------------------------------
module mme_dp #(
	parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF,
	localparam int AW = $clog2(MAX_DIM * MAX_DIM),
	localparam int PW = 2 * ELEM_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mme_pkg::cmd_t                      cmd,
	input  logic [AW-1:0]                      rd_addr_a,
	input  logic [AW-1:0]                      rd_addr_b,
	input  logic [mme_pkg::IDX_W-1:0]          row_index,
	input  logic [mme_pkg::IDX_W-1:0]          col_index,
	input  logic signed [mme_pkg::VALUE_W-1:0] elem_value,
	output logic                               done,
	output logic [mme_pkg::IDX_W-1:0]          out_row,
	output logic [mme_pkg::IDX_W-1:0]          out_col,
	output logic signed [mme_pkg::ACC_W-1:0]   out_value,
	output logic                               is_last
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic [AW-1:0]                   wr_addr;
	logic signed [ELEM_WIDTH-1:0]    wr_data;
	logic signed [ELEM_WIDTH-1:0]    a_s1, b_s1;
	logic signed [PW-1:0]            prod;
	logic signed [PW-1:0]            prod_s2;
	logic signed [mme_pkg::ACC_W-1:0] acc_q;
	logic signed [mme_pkg::ACC_W-1:0] sum;
	mme_pkg::tag_t                   tag_s1, tag_s2;

	assign wr_addr = AW'(32'(row_index) * MAX_DIM + 32'(col_index));
	assign wr_data = ELEM_WIDTH'(elem_value);

	mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
		.clk   (clk),
		.we    (cmd.wr_a),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr_a),
		.rdata (a_s1)
	);

	mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
		.clk   (clk),
		.we    (cmd.wr_b),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr_b),
		.rdata (b_s1)
	);

	assign prod = a_s1 * b_s1;
	assign sum  = (tag_s2.first ? '0 : acc_q) + mme_pkg::ACC_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			done   <= 1'b0;
		end else begin
			tag_s1.valid     <= cmd.rd;
			tag_s1.first     <= cmd.first;
			tag_s1.last_elem <= cmd.last_elem;
			tag_s1.last_all  <= cmd.last_all;
			tag_s1.out_row   <= cmd.out_row;
			tag_s1.out_col   <= cmd.out_col;
			tag_s2           <= tag_s1;
			done             <= tag_s2.valid && tag_s2.last_elem;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		if (tag_s2.valid) begin
			acc_q <= sum;
		end
		if (tag_s2.valid && tag_s2.last_elem) begin
			out_value <= sum;
			out_row   <= tag_s2.out_row;
			out_col   <= tag_s2.out_col;
			is_last   <= tag_s2.last_all;
		end
	end

endmodule

FILE: src/matrix_multiply_engine_unit.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Dense C = A x B on signed Q8.8 elements with exact Q20.16 results.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Opcode
// load A / load B writes one element (elements outside the configured sizes
// are dropped) and busy stays low, so loads may follow each other every
// cycle. A compute request raises busy while the sequencer walks (i, j, k)
// over nr, nk and nc, the configured sizes clamped to 1..MAX_DIM: one
// multiply-accumulate per cycle, limited by the single multiplier and the one
// read port of each element store. Each product passes the store read
// register, the product register and the accumulator, and results follow
// in row-major order, each on the ports for one cycle with done high and the
// final one with is_last high. Results cannot be held off by the receiver;
// capture them on the cycle done is high. Configuration registers (rows_a at
// 0x0, inner_size at 0x4, cols_b at 0x8) are to be written through the APB
// port only while no compute is in flight, which the block does not enforce;
// every store entry read by a compute must have been loaded beforehand.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit #(
	parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// APB configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mme_pkg::PADDR_W-1:0]         paddr,
	input  logic [mme_pkg::PDATA_W-1:0]         pwdata,
	output logic [mme_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready,

	// Request side
	input  logic                                start,
	output logic                                busy,
	input  logic [mme_pkg::OPC_W-1:0]           opcode,
	input  logic [mme_pkg::IDX_W-1:0]           row_index,
	input  logic [mme_pkg::IDX_W-1:0]           col_index,
	input  logic signed [mme_pkg::VALUE_W-1:0]  elem_value,

	// Result side
	output logic                                done,
	output logic [mme_pkg::IDX_W-1:0]           out_row,
	output logic [mme_pkg::IDX_W-1:0]           out_col,
	output logic signed [mme_pkg::ACC_W-1:0]    out_value,
	output logic                                is_last
);

	localparam int SW = $clog2(MAX_DIM + 1);
	localparam int AW = $clog2(MAX_DIM * MAX_DIM);

	logic [mme_pkg::CFG_W-1:0] rows_a_q, inner_size_q, cols_b_q;
	logic [SW-1:0]             nr, nk, nc;
	logic                      cfg_wr;
	logic [1:0]                reg_sel;
	mme_pkg::cmd_t             cmd;
	logic [AW-1:0]             rd_addr_a, rd_addr_b;

	// Register file: word-aligned, low address bits ignored.
	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= mme_pkg::CFG_W'(8);
			inner_size_q <= mme_pkg::CFG_W'(8);
			cols_b_q     <= mme_pkg::CFG_W'(8);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				mme_pkg::REG_ROWS_A:     rows_a_q     <= pwdata[mme_pkg::CFG_W-1:0];
				mme_pkg::REG_INNER_SIZE: inner_size_q <= pwdata[mme_pkg::CFG_W-1:0];
				mme_pkg::REG_COLS_B:     cols_b_q     <= pwdata[mme_pkg::CFG_W-1:0];
				default: begin
					// unmapped register: drop the write
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			mme_pkg::REG_ROWS_A:     prdata = mme_pkg::PDATA_W'(rows_a_q);
			mme_pkg::REG_INNER_SIZE: prdata = mme_pkg::PDATA_W'(inner_size_q);
			mme_pkg::REG_COLS_B:     prdata = mme_pkg::PDATA_W'(cols_b_q);
			default:                 prdata = '0;
		endcase
	end

	// Clamp the sizes: zero acts as one, anything above MAX_DIM as MAX_DIM.
	function automatic logic [SW-1:0] clamp_size(input logic [mme_pkg::CFG_W-1:0] r);
		logic [SW-1:0] res;
		if (r == '0) begin
			res = SW'(1);
		end else if (32'(r) > MAX_DIM) begin
			res = SW'(MAX_DIM);
		end else begin
			res = SW'(r);
		end
		return res;
	endfunction

	assign nr = clamp_size(rows_a_q);
	assign nk = clamp_size(inner_size_q);
	assign nc = clamp_size(cols_b_q);

	// Sequencer: decodes requests, walks the index space.
	mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.opcode    (opcode),
		.row_index (row_index),
		.col_index (col_index),
		.nr        (nr),
		.nk        (nk),
		.nc        (nc),
		.busy      (busy),
		.cmd       (cmd),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b)
	);

	// Datapath: stores, multiply stage, accumulate and result register.
	mme_dp #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (rd_addr_b),
		.row_index  (row_index),
		.col_index  (col_index),
		.elem_value (elem_value),
		.done       (done),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_value  (out_value),
		.is_last    (is_last)
	);

endmodule

FILE: test/matrix_multiply_engine_unit_test.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine unit test
// Streams load and compute requests in random bursts through a series of
// matrix size settings and checks each result element, in order, against a
// cycle-free predictor of C = A x B kept inside the bench.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit_test;
	import mme_pkg::*;

	localparam int DIM = MAX_DIM_DEF;
	// Opcode that the engine must ignore.
	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
	// Cycles without any accepted request, result or register write.
	localparam int IDLE_LIMIT = 2000;
	// Quiet time before a register write and at the end of the run.
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES = 32;

	typedef struct packed {
		logic [OPC_W-1:0]   op;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic [VALUE_W-1:0] value;
	} mm_request_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [ACC_W-1:0] value;
		logic             last;
	} mm_elem_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	logic                      start = 1'b0;
	logic                      busy;
	logic [OPC_W-1:0]          opcode = '0;
	logic [IDX_W-1:0]          row_index = '0;
	logic [IDX_W-1:0]          col_index = '0;
	logic signed [VALUE_W-1:0] elem_value = '0;

	logic                    done;
	logic [IDX_W-1:0]        out_row;
	logic [IDX_W-1:0]        out_col;
	logic signed [ACC_W-1:0] out_value;
	logic                    is_last;

	matrix_multiply_engine_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.row_index  (row_index),
		.col_index  (col_index),
		.elem_value (elem_value),
		.done       (done),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_value  (out_value),
		.is_last    (is_last)
	);

	always #5 clk = ~clk;

	// Predictor copy of the size registers and the element stores.
	logic [CFG_W-1:0]   size_rows = 4'd8;
	logic [CFG_W-1:0]   size_inner = 4'd8;
	logic [CFG_W-1:0]   size_cols = 4'd8;
	logic [VALUE_W-1:0] mat_a [0:DIM*DIM-1];
	logic [VALUE_W-1:0] mat_b [0:DIM*DIM-1];

	// Entries that some queued load fills; a compute is queued only once
	// every entry inside the current sizes is marked here.
	bit loaded_a [0:DIM*DIM-1];
	bit loaded_b [0:DIM*DIM-1];

	mm_request_t request_queue[$];
	mm_elem_t    product_queue[$];
	mm_request_t presented;
	mm_elem_t    head_elem;

	int queued_count = 0;
	int taken_count = 0;
	int compute_count = 0;
	int elem_count = 0;
	int error_count = 0;
	int setting_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;

	// Map a size register onto the size the engine actually uses.
	function automatic int span(input logic [CFG_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > DIM)
			return DIM;
		return int'(r);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return VALUE_W'($urandom());
		endcase
	endfunction

	// Apply one accepted request: write a store, or queue every product element.
	task automatic take_request(input mm_request_t rq);
		int nr;
		int nk;
		int nc;
		longint acc;
		mm_elem_t e;
		nr = span(size_rows);
		nk = span(size_inner);
		nc = span(size_cols);
		case (rq.op)
			OP_LOAD_A: begin
				if (rq.row < nr && rq.col < nk)
					mat_a[rq.row * DIM + rq.col] = rq.value;
			end
			OP_LOAD_B: begin
				if (rq.row < nk && rq.col < nc)
					mat_b[rq.row * DIM + rq.col] = rq.value;
			end
			OP_COMPUTE: begin
				compute_count++;
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						acc = 0;
						for (int k = 0; k < nk; k++)
							acc += longint'($signed(mat_a[i * DIM + k])) *
								longint'($signed(mat_b[k * DIM + j]));
						e.row = IDX_W'(i);
						e.col = IDX_W'(j);
						e.value = acc[ACC_W-1:0];
						e.last = (i == nr - 1) && (j == nc - 1);
						product_queue.push_back(e);
					end
				end
			end
			default: ;
		endcase
	endtask

	// Driver: present queued requests in bursts, holding each until taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				take_request(presented);
				taken_count++;
			end
			// Advance only when the slot is free: nothing shown, or just taken.
			if (!start || !busy) begin
				if (gap_left > 0 || request_queue.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					start <= 1'b0;
				end else begin
					presented = request_queue.pop_front();
					opcode <= presented.op;
					row_index <= presented.row;
					col_index <= presented.col;
					elem_value <= presented.value;
					start <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// Close the burst; a quarter of them run straight on.
						burst_left = $urandom_range(0, 15);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end
				end
			end
		end
	end

	// Monitor: every strobed result must match the oldest pending element.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (product_queue.size() == 0) begin
				$error("unexpected result: row %0d col %0d value %0d", out_row, out_col,
					out_value);
				error_count++;
			end else begin
				head_elem = product_queue.pop_front();
				if (out_row !== head_elem.row) begin
					$error("out_row: expected %0d, actual %0d", head_elem.row, out_row);
					error_count++;
				end
				if (out_col !== head_elem.col) begin
					$error("out_col: expected %0d, actual %0d", head_elem.col, out_col);
					error_count++;
				end
				if (out_value !== head_elem.value) begin
					$error("out_value: expected %0d, actual %0d", $signed(head_elem.value),
						out_value);
					error_count++;
				end
				if (is_last !== head_elem.last) begin
					$error("is_last: expected %0d, actual %0d", head_elem.last, is_last);
					error_count++;
				end
				elem_count++;
			end
		end
	end

	// Count quiet cycles; any request, result or register write resets it.
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << 2;
		// Junk in the upper bits must be dropped by the 4-bit register.
		pwdata <= {(PDATA_W-CFG_W)'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_ROWS_A:     size_rows = val;
			REG_INNER_SIZE: size_inner = val;
			REG_COLS_B:     size_cols = val;
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_sizes(input logic [CFG_W-1:0] r, k, c);
		write_reg(REG_ROWS_A, r);
		write_reg(REG_INNER_SIZE, k);
		write_reg(REG_COLS_B, c);
		setting_count++;
	endtask

	task automatic queue_request(input logic [OPC_W-1:0] op, input int row, col,
			input logic [VALUE_W-1:0] val);
		mm_request_t rq;
		rq.op = op;
		rq.row = IDX_W'(row);
		rq.col = IDX_W'(col);
		rq.value = val;
		if (op == OP_LOAD_A && row < span(size_rows) && col < span(size_inner))
			loaded_a[row * DIM + col] = 1'b1;
		if (op == OP_LOAD_B && row < span(size_inner) && col < span(size_cols))
			loaded_b[row * DIM + col] = 1'b1;
		request_queue.push_back(rq);
		queued_count++;
	endtask

	// Load every entry the current sizes reach that has no value yet; with
	// pinned, overwrite all of them with the most negative element.
	task automatic fill_stores(input bit pinned);
		for (int r = 0; r < span(size_rows); r++)
			for (int k = 0; k < span(size_inner); k++)
				if (pinned || !loaded_a[r * DIM + k])
					queue_request(OP_LOAD_A, r, k, pinned ? 16'h8000 : pick_value());
		for (int k = 0; k < span(size_inner); k++)
			for (int c = 0; c < span(size_cols); c++)
				if (pinned || !loaded_b[k * DIM + c])
					queue_request(OP_LOAD_B, k, c, pinned ? 16'h8000 : pick_value());
	endtask

	// Mostly in-range loads, some stray indices, unused opcodes and computes.
	task automatic queue_random(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				queue_request(OP_LOAD_A, $urandom_range(0, span(size_rows) - 1),
					$urandom_range(0, span(size_inner) - 1), pick_value());
			else if (pick < 70)
				queue_request(OP_LOAD_B, $urandom_range(0, span(size_inner) - 1),
					$urandom_range(0, span(size_cols) - 1), pick_value());
			else if (pick < 80)
				queue_request($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
					$urandom_range(0, 7), $urandom_range(0, 7), pick_value());
			else if (pick < 87)
				queue_request(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
					VALUE_W'($urandom()));
			else
				queue_request(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
					VALUE_W'($urandom()));
		end
	endtask

	// Hold until every queued request is taken and every element has come.
	task automatic wait_drained();
		while (taken_count != queued_count || product_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] r, k, c, input bit pinned);
		set_sizes(r, k, c);
		fill_stores(pinned);
		queue_request(OP_COMPUTE, 0, 0, 16'h0000);
		queue_random($urandom_range(5, 9));
		queue_request(OP_COMPUTE, 7, 7, 16'hffff);
		// Queue nothing more until the whole product has been checked.
		wait_drained();
		queue_random($urandom_range(5, 9));
		queue_request(OP_COMPUTE, 0, 0, 16'h0000);
		wait_drained();
		// Let the last load settle before the next register write.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: zero sizes act as 1x1x1; extremes, stray loads, unused opcode.
		set_sizes(4'd0, 4'd0, 4'd0);
		queue_request(OP_LOAD_A, 0, 0, 16'h8000);
		queue_request(OP_LOAD_B, 0, 0, 16'h8000);
		queue_request(OP_COMPUTE, 0, 0, 16'h0000);
		queue_request(OP_LOAD_A, 0, 0, 16'h7fff);
		queue_request(OP_COMPUTE, 7, 7, 16'hffff);
		queue_request(OP_LOAD_A, 1, 0, 16'h1234);
		queue_request(OP_LOAD_A, 0, 1, 16'h1234);
		queue_request(OP_LOAD_B, 1, 0, 16'h1234);
		queue_request(OP_LOAD_B, 0, 1, 16'h1234);
		queue_request(OP_LOAD_B, 7, 7, 16'hffff);
		queue_request(OP_UNUSED, 7, 7, 16'hffff);
		queue_request(OP_COMPUTE, 0, 0, 16'h0000);
		queue_request(OP_LOAD_A, 0, 0, 16'h0001);
		queue_request(OP_LOAD_B, 0, 0, 16'hffff);
		queue_request(OP_COMPUTE, 0, 0, 16'h0000);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Sizes above the maximum clamp to 8; the pinned phase builds the
		// largest sum the maximum inner size allows.
		run_phase(4'd15, 4'd1, 4'd15, 1'b0);
		run_phase(4'd1, 4'd15, 4'd1, 1'b1);
		run_phase(4'd2, 4'd3, 4'd2, 1'b0);
		run_phase(4'd3, 4'd5, 4'd4, 1'b0);
		run_phase(4'd1, 4'd1, 4'd8, 1'b0);
		run_phase(4'd8, 4'd8, 4'd8, 1'b0);
		repeat (3)
			run_phase(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 4)),
				CFG_W'($urandom_range(0, 4)), 1'b0);
		run_phase(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)),
			CFG_W'($urandom_range(0, 15)), 1'b0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d requests, %0d of them computes, over %0d size settings.",
			taken_count, compute_count, setting_count);
		$display("Checked %0d result elements with %0d mismatches.", elem_count, error_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
src/mme_pkg.sv
src/mme_ram.sv
src/mme_ctrl.sv
src/mme_dp.sv
src/matrix_multiply_engine_unit.sv
test/matrix_multiply_engine_unit_test.sv
